### sv/sactl_pkg.sv
// shared types, constants and helper functions for the cache tag lookup
package sactl_pkg;

    localparam int DEF_WAYS        = 4;
    localparam int DEF_SETS        = 64;
    localparam int DEF_BLOCK_BYTES = 16;
    localparam int DEF_ADDR_BITS   = 32;

    localparam int ADDRESS_W   = 32;
    localparam int OUTCOME_W   = 2;
    localparam int SET_INDEX_W = 6;
    localparam int WAY_INDEX_W = 2;
    localparam int TAG_VALUE_W = 22;
    localparam int WAY_MAX_W   = 4;

    typedef enum logic [OUTCOME_W-1:0] {
        OUTCOME_HIT   = 2'd0,
        OUTCOME_FILL  = 2'd1,
        OUTCOME_EVICT = 2'd2
    } outcome_t;

    typedef struct packed {
        outcome_t               outcome;
        logic [WAY_MAX_W-1:0]   way;
    } lookup_t;

    function automatic int floor_log2(input int v);
        int n;
        int x;
        n = 0;
        x = v;
        while (x > 1)
        begin
            x = x >> 1;
            n = n + 1;
        end
        return n;
    endfunction

    function automatic int index_width(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

### sv/sactl_store.sv
// tag and set state memories with reset clearing sweep and write-to-read forwarding
module sactl_store
    import sactl_pkg::*;
#(
    parameter int SETS    = DEF_SETS,
    parameter int SET_AW  = 6,
    parameter int TAGS_W  = 88,
    parameter int STATE_W = 6
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rd_en,
    input  logic [SET_AW-1:0]  rd_set,
    input  logic               wr_en,
    input  logic [SET_AW-1:0]  wr_set,
    input  logic [TAGS_W-1:0]  wr_tags,
    input  logic [STATE_W-1:0] wr_state,
    output logic [TAGS_W-1:0]  rd_tags,
    output logic [STATE_W-1:0] rd_state,
    output logic               busy
);

    logic [TAGS_W-1:0]  tag_mem [SETS];
    logic [STATE_W-1:0] state_mem [SETS];

    logic [TAGS_W-1:0]  tag_q_reg;
    logic [STATE_W-1:0] state_q_reg;
    logic               fwd_reg;
    logic [TAGS_W-1:0]  fwd_tags_reg;
    logic [STATE_W-1:0] fwd_state_reg;

    logic               clr_reg;
    logic               clr_next;
    logic [SET_AW-1:0]  clr_cnt_reg;
    logic [SET_AW-1:0]  clr_cnt_next;

    logic               st_we;
    logic [SET_AW-1:0]  st_addr;
    logic [STATE_W-1:0] st_data;

    // sweep every set once after reset, clearing valid bits and pointers
    always_comb
    begin
        clr_next     = clr_reg;
        clr_cnt_next = clr_cnt_reg;
        if (clr_reg)
        begin
            if (clr_cnt_reg == SET_AW'(SETS - 1))
            begin
                clr_next = 1'b0;
            end
            else
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
            fwd_reg     <= 1'b0;
        end
        else
        begin
            clr_reg     <= clr_next;
            clr_cnt_reg <= clr_cnt_next;
            if (rd_en)
            begin
                fwd_reg <= wr_en && (wr_set == rd_set);
            end
        end
    end

    assign st_we   = clr_reg || wr_en;
    assign st_addr = clr_reg ? clr_cnt_reg : wr_set;
    assign st_data = clr_reg ? '0 : wr_state;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tag_mem[wr_set] <= wr_tags;
        end
        if (st_we)
        begin
            state_mem[st_addr] <= st_data;
        end
        if (rd_en)
        begin
            tag_q_reg     <= tag_mem[rd_set];
            state_q_reg   <= state_mem[rd_set];
            fwd_tags_reg  <= wr_tags;
            fwd_state_reg <= wr_state;
        end
    end

    // a write to the set being read in the same cycle wins over the stale read
    assign rd_tags  = fwd_reg ? fwd_tags_reg : tag_q_reg;
    assign rd_state = fwd_reg ? fwd_state_reg : state_q_reg;
    assign busy     = clr_reg;

endmodule

### sv/sactl_decide.sv
// way compare, fill and round-robin victim choice for one set
module sactl_decide
    import sactl_pkg::*;
#(
    parameter int WAYS  = DEF_WAYS,
    parameter int TAG_W = 22,
    parameter int PTR_W = 2
)
(
    input  logic [TAG_W-1:0]       tag,
    input  logic [WAYS*TAG_W-1:0]  cur_tags,
    input  logic [WAYS+PTR_W-1:0]  cur_state,
    output lookup_t                result,
    output logic [WAYS*TAG_W-1:0]  new_tags,
    output logic [WAYS+PTR_W-1:0]  new_state
);

    logic [WAYS-1:0]  valid;
    logic [PTR_W-1:0] ptr;
    logic [PTR_W-1:0] ptr_inc;
    logic             hit;
    logic [PTR_W-1:0] hit_way;
    logic             free;
    logic [PTR_W-1:0] free_way;
    logic [PTR_W-1:0] way;
    logic [WAYS-1:0]  valid_new;
    logic [PTR_W-1:0] ptr_new;

    assign valid   = cur_state[WAYS-1:0];
    assign ptr     = cur_state[WAYS +: PTR_W];
    assign ptr_inc = (ptr == PTR_W'(WAYS - 1)) ? '0 : ptr + 1'b1;

    // lowest matching way and lowest empty way
    always_comb
    begin
        hit      = 1'b0;
        hit_way  = '0;
        free     = 1'b0;
        free_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (valid[w] && (cur_tags[w*TAG_W +: TAG_W] == tag))
            begin
                hit     = 1'b1;
                hit_way = PTR_W'(w);
            end
            if (!valid[w])
            begin
                free     = 1'b1;
                free_way = PTR_W'(w);
            end
        end
    end

    always_comb
    begin
        valid_new = valid;
        ptr_new   = ptr;
        if (hit)
        begin
            way            = hit_way;
            result.outcome = OUTCOME_HIT;
        end
        else if (free)
        begin
            way            = free_way;
            result.outcome = OUTCOME_FILL;
        end
        else
        begin
            way            = ptr;
            result.outcome = OUTCOME_EVICT;
            ptr_new        = ptr_inc;
        end
        result.way = WAY_MAX_W'(way);
        new_tags   = cur_tags;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!hit && (way == PTR_W'(w)))
            begin
                valid_new[w]                 = 1'b1;
                new_tags[w*TAG_W +: TAG_W]   = tag;
            end
        end
        new_state = {ptr_new, valid_new};
    end

endmodule

### sv/set_assoc_cache_tag_lookup.sv
// top level of the set-associative cache tag lookup with round-robin replacement
//
// One byte address per transfer is split into block offset, set index and tag. The set's
// tags and state are read from a synchronous memory into stage-1 registers, compared across
// all ways in parallel and written back as the result is loaded into the output register; a
// stalled output holds the lookup in stage 1. A write to the set read in the same cycle
// is forwarded, so consecutive addresses to one set flow at one per cycle; the sustained
// rate is one address per clock whenever the output is not stalled. After reset the block
// clears valid bits and victim pointers one set per cycle and holds in_stall high until
// every set is cleared.
module set_assoc_cache_tag_lookup
    import sactl_pkg::*;
#(
    parameter int WAYS        = DEF_WAYS,
    parameter int SETS        = DEF_SETS,
    parameter int BLOCK_BYTES = DEF_BLOCK_BYTES,
    parameter int ADDR_BITS   = DEF_ADDR_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [ADDRESS_W-1:0]   address,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [OUTCOME_W-1:0]   outcome,
    output logic [SET_INDEX_W-1:0] set_index,
    output logic [WAY_INDEX_W-1:0] way_index,
    output logic [TAG_VALUE_W-1:0] tag_value
);

    localparam int OFF_B   = floor_log2(BLOCK_BYTES);
    localparam int SET_B   = floor_log2(SETS);
    localparam int SET_AW  = index_width(SETS);
    localparam int PTR_W   = index_width(WAYS);
    localparam int ABITS   = (ADDR_BITS < ADDRESS_W) ? ADDR_BITS : ADDRESS_W;
    localparam int TAG_RAW = ABITS - OFF_B - SET_B;
    localparam int TAG_W   = (TAG_RAW > 0) ? TAG_RAW : 1;
    localparam int TAGS_W  = WAYS * TAG_W;
    localparam int STATE_W = WAYS + PTR_W;
    localparam logic [ADDRESS_W-1:0] ADDR_MASK = {ADDRESS_W{1'b1}} >> (ADDRESS_W - ABITS);
    localparam logic [ADDRESS_W-1:0] SET_MASK  = (ADDRESS_W'(1) << SET_B) - 1'b1;

    logic [ADDRESS_W-1:0] addr_m;
    logic [ADDRESS_W-1:0] set_full;
    logic [ADDRESS_W-1:0] tag_full;
    logic [SET_AW-1:0]    in_set;
    logic [TAG_W-1:0]     in_tag;
    logic                 in_fire;
    logic                 s1_fire;
    logic                 busy;

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic [SET_AW-1:0]    s1_set_reg;
    logic [TAG_W-1:0]     s1_tag_reg;

    logic [TAGS_W-1:0]    cur_tags;
    logic [STATE_W-1:0]   cur_state;
    logic [TAGS_W-1:0]    new_tags;
    logic [STATE_W-1:0]   new_state;
    lookup_t              result;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [OUTCOME_W-1:0]   outcome_reg;
    logic [SET_INDEX_W-1:0] set_index_reg;
    logic [WAY_INDEX_W-1:0] way_index_reg;
    logic [TAG_VALUE_W-1:0] tag_value_reg;

    assign addr_m   = address & ADDR_MASK;
    assign set_full = (addr_m >> OFF_B) & SET_MASK;
    assign tag_full = addr_m >> (OFF_B + SET_B);
    assign in_set   = SET_AW'(set_full);
    assign in_tag   = TAG_W'(tag_full);

    assign s1_fire  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = busy || (s1_valid_reg && !s1_fire);
    assign in_fire  = in_valid && !in_stall;

    sactl_store #(
        .SETS    (SETS),
        .SET_AW  (SET_AW),
        .TAGS_W  (TAGS_W),
        .STATE_W (STATE_W)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (in_fire),
        .rd_set   (in_set),
        .wr_en    (s1_fire),
        .wr_set   (s1_set_reg),
        .wr_tags  (new_tags),
        .wr_state (new_state),
        .rd_tags  (cur_tags),
        .rd_state (cur_state),
        .busy     (busy)
    );

    sactl_decide #(
        .WAYS  (WAYS),
        .TAG_W (TAG_W),
        .PTR_W (PTR_W)
    ) u_decide (
        .tag       (s1_tag_reg),
        .cur_tags  (cur_tags),
        .cur_state (cur_state),
        .result    (result),
        .new_tags  (new_tags),
        .new_state (new_state)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (s1_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_set_reg <= in_set;
            s1_tag_reg <= in_tag;
        end
        if (s1_fire)
        begin
            outcome_reg   <= result.outcome;
            set_index_reg <= SET_INDEX_W'(s1_set_reg);
            way_index_reg <= WAY_INDEX_W'(result.way);
            tag_value_reg <= TAG_VALUE_W'(s1_tag_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign outcome   = outcome_reg;
    assign set_index = set_index_reg;
    assign way_index = way_index_reg;
    assign tag_value = tag_value_reg;

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the set-associative cache tag lookup with round-robin replacement
module tb;
    import sactl_pkg::*;

    typedef struct {
        outcome_t                outcome;
        logic [SET_INDEX_W-1:0]  set_index;
        logic [WAY_INDEX_W-1:0]  way_index;
        logic [TAG_VALUE_W-1:0]  tag_value;
    } lookup_result_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [ADDRESS_W-1:0]    address = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [OUTCOME_W-1:0]    outcome;
    logic [SET_INDEX_W-1:0]  set_index;
    logic [WAY_INDEX_W-1:0]  way_index;
    logic [TAG_VALUE_W-1:0]  tag_value;

    // shadow copy of the tag store
    bit                      line_valid [DEF_SETS][DEF_WAYS];
    logic [TAG_VALUE_W-1:0]  line_tag [DEF_SETS][DEF_WAYS];
    bit [WAY_INDEX_W-1:0]    victim_ptr [DEF_SETS];

    lookup_result_t          expected_lookups [$];
    logic [TAG_VALUE_W-1:0]  hot_tags [8];
    logic [SET_INDEX_W-1:0]  hot_sets [4];
    int                      mismatch_count = 0;
    int                      send_idle_pct = 0;
    int                      recv_stall_pct = 0;

    set_assoc_cache_tag_lookup dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .address   (address),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .outcome   (outcome),
        .set_index (set_index),
        .way_index (way_index),
        .tag_value (tag_value)
    );

    always #6 clk = ~clk;

    function automatic lookup_result_t predict_lookup(input logic [ADDRESS_W-1:0] a);
        lookup_result_t r;
        logic [SET_INDEX_W-1:0] s;
        logic [TAG_VALUE_W-1:0] t;
        bit done;
        s = a[9:4];
        t = a[31:10];
        done = 1'b0;
        r.set_index = s;
        r.tag_value = t;
        r.way_index = '0;
        r.outcome = OUTCOME_HIT;
        for (int w = 0; w < DEF_WAYS; w++)
        begin
            if (!done && line_valid[s][w] && line_tag[s][w] == t)
            begin
                done = 1'b1;
                r.way_index = WAY_INDEX_W'(w);
            end
        end
        // lowest empty way first
        for (int w = 0; w < DEF_WAYS; w++)
        begin
            if (!done && !line_valid[s][w])
            begin
                done = 1'b1;
                r.outcome = OUTCOME_FILL;
                r.way_index = WAY_INDEX_W'(w);
                line_valid[s][w] = 1'b1;
                line_tag[s][w] = t;
            end
        end
        if (!done)
        begin
            r.outcome = OUTCOME_EVICT;
            r.way_index = victim_ptr[s];
            line_tag[s][victim_ptr[s]] = t;
            victim_ptr[s] = victim_ptr[s] + 1'b1;
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic send_address(input logic [ADDRESS_W-1:0] a);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            address <= $urandom;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        address <= a;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_lookups.push_back(predict_lookup(a));
    endtask

    function automatic logic [ADDRESS_W-1:0] pick_address();
        int mode;
        logic [TAG_VALUE_W-1:0] t;
        logic [SET_INDEX_W-1:0] s;
        logic [3:0] o;
        mode = $urandom_range(99);
        t = hot_tags[$urandom_range(7)];
        o = 4'($urandom_range(15));
        if (mode < 20)
            return $urandom;
        if (mode < 50)
            s = hot_sets[$urandom_range(3)];
        else
            s = SET_INDEX_W'($urandom_range(63));
        return {t, s, o};
    endfunction

    // checks each result transfer against the oldest prediction
    always @(posedge clk)
    begin
        lookup_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_lookups.size() == 0)
            begin
                $display("%0t: unexpected result, expected none actual outcome %0h set %0h",
                         $time, outcome, set_index);
                mismatch_count++;
            end
            else
            begin
                want = expected_lookups.pop_front();
                check_field("outcome", 32'(want.outcome), 32'(outcome));
                check_field("set_index", 32'(want.set_index), 32'(set_index));
                check_field("way_index", 32'(want.way_index), 32'(way_index));
                check_field("tag_value", 32'(want.tag_value), 32'(tag_value));
            end
        end
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic test_cold_fill_and_hit();
        send_address(32'h0000_0000);
        send_address(32'h0000_000f);
        send_address(32'hffff_ffff);
        send_address(32'hffff_fff0);
    endtask

    task automatic test_set_eviction();
        // set 5: fill all four ways, then rotate the victim
        for (int i = 1; i <= 7; i++)
            send_address({22'(i), 6'd5, 4'd0});
        send_address({22'd6, 6'd5, 4'd9});
        send_address({22'd1, 6'd5, 4'd3});
        send_address({22'd2, 6'd5, 4'd15});
    endtask

    task automatic test_bit_patterns();
        send_address(32'haaaa_aaaa);
        send_address(32'h5555_5555);
        send_address(32'h8000_0000);
        send_address(32'h0000_0001);
    endtask

    task automatic test_random_traffic(input int count, input int idle_pct,
                                       input int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
            send_address(pick_address());
    endtask

    initial
    begin
        hot_tags[0] = '0;
        hot_tags[1] = '1;
        for (int i = 2; i < 8; i++)
            hot_tags[i] = TAG_VALUE_W'($urandom);
        for (int i = 0; i < 4; i++)
            hot_sets[i] = SET_INDEX_W'($urandom_range(63));
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_cold_fill_and_hit();
        test_set_eviction();
        test_bit_patterns();
        test_random_traffic(138, 0, 0);
        test_random_traffic(138, 73, 0);
        test_random_traffic(138, 0, 73);
        test_random_traffic(138, 22, 22);
        in_valid <= 1'b0;
        while (expected_lookups.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("set_assoc_cache_tag_lookup regression: pass");
        else
            $display("set_assoc_cache_tag_lookup regression: fail");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("set_assoc_cache_tag_lookup regression: fail");
        $finish;
    end

endmodule
